[hw/rtl/phc_pkg.sv]
`default_nettype none
package phc_pkg;
    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int MAX_PIXELS_DEF   = 32;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int SIZE_W  = 6;
    localparam int REACH_W = 3;
    localparam int PIX_W   = COL_W + ROW_W;

    // configuration register indexes
    localparam logic REG_COL_REACH = 1'b0;
    localparam logic REG_ROW_REACH = 1'b1;

    localparam logic [REACH_W-1:0] COL_REACH_RST = 3'd1;
    localparam logic [REACH_W-1:0] ROW_REACH_RST = 3'd1;
endpackage
`default_nettype wire

[hw/rtl/phc_ram.sv]
`default_nettype none
module phc_ram #(
    parameter int WIDTH = phc_pkg::PIX_W,
    parameter int DEPTH = phc_pkg::MAX_CLUSTERS_DEF * phc_pkg::MAX_PIXELS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [AW-1:0]           waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic [AW-1:0]           raddr,
    output logic      [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[hw/rtl/phc_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle
module phc_div #(
    parameter int NW = 17
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [NW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo,
    output logic [NW-1:0]      rem
);
    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [NW:0]     rem_reg;
    logic [NW-1:0]   quo_reg;
    logic [NW-1:0]   num_reg;
    logic [NW-1:0]   den_reg;
    logic [NW:0]     trial;

    assign trial = {rem_reg[NW-1:0], num_reg[NW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW);
                rem_reg  <= '0;
                quo_reg  <= '0;
                num_reg  <= num;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= trial - {1'b0, den_reg};
                    quo_reg <= {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[NW-2:0], 1'b0};
                end
                num_reg <= {num_reg[NW-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg[NW-1:0];
endmodule
`default_nettype wire

[hw/rtl/pixel_hit_clusterer_top.sv]
`default_nettype none
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | flush, pixel_col, pixel_row
// out     | output    | out_valid / out_stall | mean_col, mean_row, col_half,
//         |           |                       | row_half, cluster_size, end_of_chip
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A hit visits the cluster slots in order and is compared against each stored pixel,
// read one at a time through the pixel memory read port; opening or joining ends the item.
// Each emitted cluster runs a column then a row division in the shared divider
// (NW = 11 + clog2(MAX_PIXELS + 1)), and may also wait on an output stall.
// in_stall stays high until the item is finished. Reset clears all cluster slots at once.
module pixel_hit_clusterer_top #(
    parameter int MAX_CLUSTERS = phc_pkg::MAX_CLUSTERS_DEF,
    parameter int MAX_PIXELS   = phc_pkg::MAX_PIXELS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         flush,
    input  wire logic [phc_pkg::COL_W-1:0]    pixel_col,
    input  wire logic [phc_pkg::ROW_W-1:0]    pixel_row,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [phc_pkg::COL_W-1:0]         mean_col,
    output logic [phc_pkg::ROW_W-1:0]         mean_row,
    output logic                              col_half,
    output logic                              row_half,
    output logic [phc_pkg::SIZE_W-1:0]        cluster_size,
    output logic                              end_of_chip,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic                         cfg_index,
    input  wire logic [phc_pkg::REACH_W-1:0]  cfg_data
);
    localparam int COL_W = phc_pkg::COL_W;
    localparam int ROW_W = phc_pkg::ROW_W;
    localparam int PW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int LW    = $clog2(MAX_CLUSTERS + 1);
    localparam int CW    = $clog2(MAX_PIXELS + 1);
    localparam int DEPTH = MAX_CLUSTERS * MAX_PIXELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SCW   = COL_W + CW;
    localparam int SRW   = ROW_W + CW;
    localparam int NW    = SCW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SLOT, S_RD, S_CMP, S_DIVC_GO, S_DIVC_WAIT,
        S_DIVR_GO, S_DIVR_WAIT, S_OUT, S_EMPTY
    } state_t;

    state_t                     state_reg;
    logic [phc_pkg::REACH_W-1:0] col_reach_reg;
    logic [phc_pkg::REACH_W-1:0] row_reach_reg;
    logic                       flush_reg;
    logic [COL_W-1:0]           hc_reg;
    logic [ROW_W-1:0]           hr_reg;
    logic [LW-1:0]              slot_reg;
    logic [LW-1:0]              nopen_reg;
    logic [CW-1:0]              k_reg;
    logic [PW-1:0]              map_reg [MAX_CLUSTERS];
    // per physical slot
    logic [CW-1:0]              count_reg [MAX_CLUSTERS];
    logic [SCW-1:0]             scol_reg  [MAX_CLUSTERS];
    logic [SRW-1:0]             srow_reg  [MAX_CLUSTERS];
    logic [COL_W-1:0]           lcol_reg  [MAX_CLUSTERS];

    logic [COL_W-1:0]           qcol_reg;
    logic                       hcol_reg;
    logic [ROW_W-1:0]           qrow_reg;
    logic                       hrow_reg;

    logic                       out_valid_reg;
    logic [COL_W-1:0]           ccol_reg;
    logic [ROW_W-1:0]           crow_reg;
    logic                       chalf_reg;
    logic                       rhalf_reg;
    logic [phc_pkg::SIZE_W-1:0] size_reg;
    logic                       eoc_reg;

    logic [PW-1:0]              phys;
    logic [CW-1:0]              n_cur;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [AW-1:0]              ram_raddr;
    logic [phc_pkg::PIX_W-1:0]  ram_rdata;
    logic [phc_pkg::PIX_W-1:0]  hit_word;
    logic [COL_W-1:0]           pc;
    logic [ROW_W-1:0]           pr;
    logic signed [COL_W:0]      dc;
    logic signed [ROW_W:0]      dr;
    logic signed [COL_W:0]      dlast;
    logic                       match;
    logic                       out_free;
    logic                       out_load;
    logic                       div_start;
    logic [NW-1:0]              div_num;
    logic [NW-1:0]              div_den;
    logic                       div_done;
    logic [NW-1:0]              div_quo;
    logic [NW-1:0]              div_rem;
    logic                       div_half;

    assign phys     = map_reg[slot_reg[PW-1:0]];
    assign n_cur    = count_reg[phys];
    assign hit_word = {hc_reg, hr_reg};
    assign pc       = ram_rdata[phc_pkg::PIX_W-1:ROW_W];
    assign pr       = ram_rdata[ROW_W-1:0];
    assign dc       = $signed({1'b0, hc_reg}) - $signed({1'b0, pc});
    assign dr       = $signed({1'b0, hr_reg}) - $signed({1'b0, pr});
    assign dlast    = $signed({1'b0, hc_reg}) - $signed({1'b0, lcol_reg[phys]});
    assign match    = (dc >= 0) && (dc <= $signed({8'd0, col_reach_reg}))
                   && (dr >= -$signed({7'd0, row_reach_reg}))
                   && (dr <= $signed({7'd0, row_reach_reg}));
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = ((state_reg == S_OUT) || (state_reg == S_EMPTY)) && out_free;

    // open writes entry 0, append writes entry n
    assign ram_we    = ((state_reg == S_SLOT) && (slot_reg < nopen_reg) == 1'b0
                        && slot_reg != LW'(MAX_CLUSTERS))
                    || ((state_reg == S_CMP) && match && n_cur < CW'(MAX_PIXELS));
    assign ram_waddr = (state_reg == S_SLOT) ? AW'(32'(phys) * 32'(MAX_PIXELS))
                     : AW'(32'(phys) * 32'(MAX_PIXELS) + 32'(n_cur));
    assign ram_raddr = AW'(32'(phys) * 32'(MAX_PIXELS) + 32'(k_reg));

    phc_ram #(
        .WIDTH (phc_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (hit_word),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_start = (state_reg == S_DIVC_GO) || (state_reg == S_DIVR_GO);
    assign div_num   = (state_reg == S_DIVR_GO)
                     ? NW'({srow_reg[phys], 1'b0}) + NW'(n_cur)
                     : NW'({scol_reg[phys], 1'b0}) + NW'(n_cur);
    assign div_den   = NW'({n_cur, 1'b0});
    assign div_half  = (div_rem >= NW'(n_cur));

    phc_div #(
        .NW (NW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reach_reg <= phc_pkg::COL_REACH_RST;
            row_reach_reg <= phc_pkg::ROW_REACH_RST;
            nopen_reg     <= '0;
            slot_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CLUSTERS; i++)
            begin
                map_reg[i] <= PW'(i);
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    phc_pkg::REG_COL_REACH: col_reach_reg <= cfg_data;
                    phc_pkg::REG_ROW_REACH: row_reach_reg <= cfg_data;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        flush_reg <= flush;
                        hc_reg    <= pixel_col;
                        hr_reg    <= pixel_row;
                        slot_reg  <= '0;
                        if (!flush)
                            state_reg <= S_SLOT;
                        else if (nopen_reg == '0)
                            state_reg <= S_EMPTY;
                        else
                            state_reg <= S_DIVC_GO;
                    end
                end
                S_SLOT:
                begin
                    k_reg <= '0;
                    if (slot_reg < nopen_reg)
                    begin
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        // store full drops the hit
                        if (slot_reg != LW'(MAX_CLUSTERS))
                        begin
                            count_reg[phys] <= CW'(1);
                            scol_reg[phys]  <= SCW'(hc_reg);
                            srow_reg[phys]  <= SRW'(hr_reg);
                            lcol_reg[phys]  <= hc_reg;
                            nopen_reg       <= nopen_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (match)
                    begin
                        // a full cluster drops the hit
                        if (n_cur < CW'(MAX_PIXELS))
                        begin
                            count_reg[phys] <= n_cur + 1'b1;
                            scol_reg[phys]  <= scol_reg[phys] + SCW'(hc_reg);
                            srow_reg[phys]  <= srow_reg[phys] + SRW'(hr_reg);
                            lcol_reg[phys]  <= hc_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                    else if (k_reg + 1'b1 < n_cur)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                    else if (dlast > $signed({8'd0, col_reach_reg}))
                    begin
                        state_reg <= S_DIVC_GO;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= S_SLOT;
                    end
                end
                S_DIVC_GO:
                begin
                    state_reg <= S_DIVC_WAIT;
                end
                S_DIVC_WAIT:
                begin
                    if (div_done)
                    begin
                        qcol_reg  <= div_quo[COL_W-1:0];
                        hcol_reg  <= div_half;
                        state_reg <= S_DIVR_GO;
                    end
                end
                S_DIVR_GO:
                begin
                    state_reg <= S_DIVR_WAIT;
                end
                S_DIVR_WAIT:
                begin
                    if (div_done)
                    begin
                        qrow_reg  <= div_quo[ROW_W-1:0];
                        hrow_reg  <= div_half;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        ccol_reg      <= qcol_reg;
                        chalf_reg     <= hcol_reg;
                        crow_reg      <= qrow_reg;
                        rhalf_reg     <= hrow_reg;
                        size_reg      <= phc_pkg::SIZE_W'(n_cur);
                        eoc_reg       <= flush_reg && (nopen_reg == LW'(1));
                        // drop the slot from the order, its storage goes to the tail
                        for (int j = 0; j < MAX_CLUSTERS - 1; j++)
                        begin
                            if (LW'(j) >= slot_reg)
                                map_reg[j] <= map_reg[j + 1];
                        end
                        map_reg[MAX_CLUSTERS - 1] <= phys;
                        nopen_reg <= nopen_reg - 1'b1;
                        if (!flush_reg)
                            state_reg <= S_SLOT;
                        else if (nopen_reg == LW'(1))
                            state_reg <= S_IDLE;
                        else
                            state_reg <= S_DIVC_GO;
                    end
                end
                S_EMPTY:
                begin
                    if (out_free)
                    begin
                        ccol_reg      <= '0;
                        crow_reg      <= '0;
                        chalf_reg     <= 1'b0;
                        rhalf_reg     <= 1'b0;
                        size_reg      <= '0;
                        eoc_reg       <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign mean_col     = ccol_reg;
    assign mean_row     = crow_reg;
    assign col_half     = chalf_reg;
    assign row_half     = rhalf_reg;
    assign cluster_size = size_reg;
    assign end_of_chip  = eoc_reg;
endmodule
`default_nettype wire

[hw/rtl/phc_checker.sv]
`default_nettype none
module phc_port_props (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [phc_pkg::COL_W-1:0]   mean_col,
    input wire logic                        col_half,
    input wire logic                        row_half,
    input wire logic [phc_pkg::SIZE_W-1:0]  cluster_size,
    input wire logic                        end_of_chip
);
    // result held while the sink stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mean_col)
                                   && $stable(cluster_size))
        else $error("stalled result changed");

    // in_stall is raised in the cycle after an item is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("accepted next item too early");

    // the empty marker only closes a flush and carries zero fields
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cluster_size == '0 |-> end_of_chip && !col_half && !row_half
                                           && mean_col == '0)
        else $error("bad empty result");

    // a fresh result never appears while the block waits for an item
    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && !out_valid |=> !out_valid || $past(in_valid))
        else $error("result without an item");
endmodule

bind pixel_hit_clusterer_top phc_port_props u_phc_port_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mean_col     (mean_col),
    .col_half     (col_half),
    .row_half     (row_half),
    .cluster_size (cluster_size),
    .end_of_chip  (end_of_chip)
);
`default_nettype wire
